/* rtl/txtcon_pkg.sv */
// Shared types and constants for the text console character engine.
// Used by text_console_char_engine and its port checker; no dependencies.
package txtcon_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Port field widths
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = CHAR_W + ATTR_W;
    localparam int POS_W  = 11;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

    // Attribute after reset: white on black
    localparam logic [ATTR_W-1:0] RESET_COLOR = 8'h0F;

    typedef enum logic [OP_W-1:0] {
        OP_PUT    = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_SETCUR = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_BLANK,
        ST_CLEAR,
        ST_RESULT
    } state_t;

endpackage

/* rtl/text_console_char_engine.sv */
// Text console character engine: screen store, cursor and control-code handling.
// Depends on txtcon_pkg for field widths, character codes, opcodes and states.
// Checked by txtcon_port_checker (bound in its own file).

// A text console of ROWS x COLUMNS 16-bit cells (attribute high byte, character
// low byte) held in one single-port-write, registered-read screen memory, plus
// a cursor. Each accepted transaction produces exactly one result transaction.
// Put character (ordinary bytes, newline, carriage return, tab, backspace),
// read cell and set cursor each execute against the screen memory in ST_EXEC
// and then load the result register in ST_RESULT, where the next request is
// taken once the result register is free. Clear screen, and a put character
// that runs off the bottom row, sweep the screen memory one cell per cycle
// through its single write port (the scroll copies each row up with reads
// running one cell ahead of writes, then blanks the bottom row). After reset
// the block runs a clearing pass, filling every cell with a space in attribute
// 0x0F; s_ready stays low meanwhile, while text_color writes are still taken.
// Write text_color only while no transaction is in flight.
module text_console_char_engine #(
    parameter int COLUMNS = txtcon_pkg::DEF_COLUMNS,
    parameter int ROWS    = txtcon_pkg::DEF_ROWS
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // Configuration: text_color
    input  logic                            cfg_wr_en,
    input  logic [txtcon_pkg::ATTR_W-1:0]   cfg_wr_data,

    // Request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [txtcon_pkg::OP_W-1:0]     s_operation,
    input  logic [txtcon_pkg::CHAR_W-1:0]   s_char_code,
    input  logic [txtcon_pkg::ROW_W-1:0]    s_target_row,
    input  logic [txtcon_pkg::COL_W-1:0]    s_target_column,

    // Result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [txtcon_pkg::CELL_W-1:0]   m_cell_value,
    output logic [txtcon_pkg::ROW_W-1:0]    m_cursor_row,
    output logic [txtcon_pkg::COL_W-1:0]    m_cursor_column,
    output logic [txtcon_pkg::POS_W-1:0]    m_cursor_position,
    output logic                            m_scrolled
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int COPY_N = (ROWS - 1) * COLUMNS;   // cells moved by a scroll
    localparam int AW     = $clog2(CELLS);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLUMNS);

    localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_LAST = AW'(COPY_N);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    txtcon_pkg::state_t                 state_reg, state_next;
    logic [AW-1:0]                      cnt_reg, cnt_next;
    logic [RW-1:0]                      cur_row_reg, cur_row_next;
    logic [CW-1:0]                      cur_col_reg, cur_col_next;
    logic [AW-1:0]                      cur_pos_reg, cur_pos_next;
    logic                               scroll_reg, scroll_next;
    logic [txtcon_pkg::ATTR_W-1:0]      text_color_reg;

    // Latched request
    txtcon_pkg::op_t                    op_reg;
    logic [txtcon_pkg::CHAR_W-1:0]      chr_reg;
    logic [txtcon_pkg::ROW_W-1:0]       trow_reg;
    logic [txtcon_pkg::COL_W-1:0]       tcol_reg;

    // Result output register
    logic                               m_valid_reg;
    logic [txtcon_pkg::CELL_W-1:0]      m_cell_value_reg;
    logic [txtcon_pkg::ROW_W-1:0]       m_cursor_row_reg;
    logic [txtcon_pkg::COL_W-1:0]       m_cursor_column_reg;
    logic [txtcon_pkg::POS_W-1:0]       m_cursor_position_reg;
    logic                               m_scrolled_reg;

    // Screen memory
    logic [txtcon_pkg::CELL_W-1:0]      screen_mem [CELLS];
    logic [txtcon_pkg::CELL_W-1:0]      rd_data_reg;
    logic                               mem_we;
    logic [AW-1:0]                      mem_wa;
    logic [txtcon_pkg::CELL_W-1:0]      mem_wd;
    logic                               mem_re;
    logic [AW-1:0]                      mem_ra;

    // Handshake helpers
    logic                               in_load;
    logic                               out_free;
    logic                               out_load;

    // Execute-stage datapath
    logic [CW:0]                        col_t;
    logic [RW:0]                        row_t;
    logic [CW:0]                        tab_sum;
    logic                               put_we;
    logic [AW-1:0]                      put_wa;
    logic [txtcon_pkg::CELL_W-1:0]      put_wd;
    logic                               put_scroll;
    logic [RW-1:0]                      put_row;
    logic [CW-1:0]                      put_col;
    logic [RW-1:0]                      clamp_r;
    logic [CW-1:0]                      clamp_c;
    logic [RW-1:0]                      mul_row;
    logic [CW-1:0]                      mul_col;
    logic [AW-1:0]                      mul_pos;
    logic [AW:0]                        copy_src;
    logic [txtcon_pkg::CELL_W-1:0]      blank_cell;

    assign out_free   = !m_valid_reg || m_ready;
    assign in_load    = s_valid && s_ready;
    assign blank_cell = {text_color_reg, txtcon_pkg::BLANK_CHAR};
    // Scroll source runs one row ahead of the destination
    assign copy_src   = {1'b0, cnt_reg} + (AW+1)'(COLUMNS);

    // ------------------------------------------------------------------
    // Execute-stage arithmetic: new cursor for put character, clamped
    // targets, and one shared row*COLUMNS+column product
    // ------------------------------------------------------------------
    always_comb begin
        col_t      = {1'b0, cur_col_reg};
        row_t      = {1'b0, cur_row_reg};
        tab_sum    = {1'b0, cur_col_reg} + (CW+1)'(8);
        put_we     = 1'b0;
        put_wa     = cur_pos_reg;
        put_wd     = blank_cell;

        case (chr_reg)
            txtcon_pkg::CH_NL: begin
                col_t = '0;
                row_t = row_t + (RW+1)'(1);
            end
            txtcon_pkg::CH_CR: begin
                col_t = '0;
            end
            txtcon_pkg::CH_TAB: begin
                col_t = {tab_sum[CW:3], 3'b000};
            end
            txtcon_pkg::CH_BS: begin
                // Only within the row: nothing happens at column 0
                if (cur_col_reg != '0) begin
                    col_t  = col_t - (CW+1)'(1);
                    put_we = 1'b1;
                    put_wa = cur_pos_reg - AW'(1);
                end
            end
            default: begin
                put_we = 1'b1;
                put_wd = {text_color_reg, chr_reg};
                col_t  = col_t + (CW+1)'(1);
            end
        endcase

        // Wrap past the last column
        if (col_t >= (CW+1)'(COLUMNS)) begin
            col_t = '0;
            row_t = row_t + (RW+1)'(1);
        end

        put_scroll = (row_t >= (RW+1)'(ROWS));
        put_row    = put_scroll ? RW'(ROWS - 1) : row_t[RW-1:0];
        put_col    = col_t[CW-1:0];

        clamp_r = (32'(trow_reg) > ROWS - 1) ? RW'(ROWS - 1)    : RW'(trow_reg);
        clamp_c = (32'(tcol_reg) > COLUMNS - 1) ? CW'(COLUMNS - 1) : CW'(tcol_reg);

        case (op_reg)
            txtcon_pkg::OP_PUT: begin
                mul_row = put_row;
                mul_col = put_col;
            end
            txtcon_pkg::OP_CLEAR: begin
                mul_row = '0;
                mul_col = '0;
            end
            default: begin
                mul_row = clamp_r;
                mul_col = clamp_c;
            end
        endcase

        mul_pos = AW'(32'(mul_row) * COLUMNS + 32'(mul_col));
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            txtcon_pkg::ST_INIT: begin
                if (cnt_reg == LAST_ADDR) state_next = txtcon_pkg::ST_IDLE;
            end
            txtcon_pkg::ST_IDLE: begin
                if (s_valid) state_next = txtcon_pkg::ST_EXEC;
            end
            txtcon_pkg::ST_EXEC: begin
                case (op_reg)
                    txtcon_pkg::OP_PUT:   state_next = put_scroll ? txtcon_pkg::ST_COPY
                                                                  : txtcon_pkg::ST_RESULT;
                    txtcon_pkg::OP_CLEAR: state_next = txtcon_pkg::ST_CLEAR;
                    default:              state_next = txtcon_pkg::ST_RESULT;
                endcase
            end
            txtcon_pkg::ST_COPY: begin
                if (cnt_reg == COPY_LAST) state_next = txtcon_pkg::ST_BLANK;
            end
            txtcon_pkg::ST_BLANK, txtcon_pkg::ST_CLEAR: begin
                if (cnt_reg == LAST_ADDR) state_next = txtcon_pkg::ST_RESULT;
            end
            txtcon_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = s_valid ? txtcon_pkg::ST_EXEC : txtcon_pkg::ST_IDLE;
                end
            end
            default: state_next = txtcon_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs: memory port, counter, cursor, handshake
    // ------------------------------------------------------------------
    always_comb begin
        mem_we       = 1'b0;
        mem_wa       = cnt_reg;
        mem_wd       = blank_cell;
        mem_re       = 1'b0;
        mem_ra       = cnt_reg;
        cnt_next     = cnt_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        cur_pos_next = cur_pos_reg;
        scroll_next  = scroll_reg;
        out_load     = 1'b0;
        s_ready      = 1'b0;

        case (state_reg)
            txtcon_pkg::ST_INIT: begin
                // Power-up fill uses the reset attribute, not the register
                mem_we   = 1'b1;
                mem_wd   = {txtcon_pkg::RESET_COLOR, txtcon_pkg::BLANK_CHAR};
                cnt_next = cnt_reg + AW'(1);
            end
            txtcon_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            txtcon_pkg::ST_EXEC: begin
                cnt_next    = '0;
                scroll_next = 1'b0;
                case (op_reg)
                    txtcon_pkg::OP_PUT: begin
                        mem_we       = put_we;
                        mem_wa       = put_wa;
                        mem_wd       = put_wd;
                        cur_row_next = put_row;
                        cur_col_next = put_col;
                        cur_pos_next = mul_pos;
                        scroll_next  = put_scroll;
                    end
                    txtcon_pkg::OP_READ: begin
                        mem_re = 1'b1;
                        mem_ra = mul_pos;
                    end
                    txtcon_pkg::OP_CLEAR: begin
                        cur_row_next = '0;
                        cur_col_next = '0;
                        cur_pos_next = '0;
                    end
                    default: begin
                        cur_row_next = clamp_r;
                        cur_col_next = clamp_c;
                        cur_pos_next = mul_pos;
                    end
                endcase
            end
            txtcon_pkg::ST_COPY: begin
                // Read one row ahead; write the cell read last cycle
                mem_re   = (cnt_reg < COPY_LAST);
                mem_ra   = copy_src[AW-1:0];
                mem_we   = (cnt_reg != '0);
                mem_wa   = cnt_reg - AW'(1);
                mem_wd   = rd_data_reg;
                cnt_next = (cnt_reg == COPY_LAST) ? cnt_reg : cnt_reg + AW'(1);
            end
            txtcon_pkg::ST_BLANK, txtcon_pkg::ST_CLEAR: begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + AW'(1);
            end
            txtcon_pkg::ST_RESULT: begin
                out_load = out_free;
                s_ready  = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= txtcon_pkg::ST_INIT;
            cnt_reg        <= '0;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            cur_pos_reg    <= '0;
            scroll_reg     <= 1'b0;
            text_color_reg <= txtcon_pkg::RESET_COLOR;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            cur_pos_reg <= cur_pos_next;
            scroll_reg  <= scroll_next;
            if (cfg_wr_en) text_color_reg <= cfg_wr_data;
            // Hold the result until taken; a new one lands as the old leaves
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_load) begin
            op_reg   <= txtcon_pkg::op_t'(s_operation);
            chr_reg  <= s_char_code;
            trow_reg <= s_target_row;
            tcol_reg <= s_target_column;
        end
        if (out_load) begin
            m_cell_value_reg      <= (op_reg == txtcon_pkg::OP_READ) ? rd_data_reg : '0;
            m_cursor_row_reg      <= txtcon_pkg::ROW_W'(cur_row_reg);
            m_cursor_column_reg   <= txtcon_pkg::COL_W'(cur_col_reg);
            m_cursor_position_reg <= txtcon_pkg::POS_W'(cur_pos_reg);
            m_scrolled_reg        <= scroll_reg;
        end
    end

    // ------------------------------------------------------------------
    // Screen memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) screen_mem[mem_wa] <= mem_wd;
        if (mem_re) rd_data_reg <= screen_mem[mem_ra];
    end

    assign m_valid           = m_valid_reg;
    assign m_cell_value      = m_cell_value_reg;
    assign m_cursor_row      = m_cursor_row_reg;
    assign m_cursor_column   = m_cursor_column_reg;
    assign m_cursor_position = m_cursor_position_reg;
    assign m_scrolled        = m_scrolled_reg;

endmodule

/* rtl/txtcon_port_checker.sv */
// Port-level checker for text_console_char_engine, with its bind statement.
// Depends on txtcon_pkg for field widths.
module txtcon_port_checker #(
    parameter int COLUMNS = txtcon_pkg::DEF_COLUMNS,
    parameter int ROWS    = txtcon_pkg::DEF_ROWS
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [txtcon_pkg::CELL_W-1:0]   m_cell_value,
    input logic [txtcon_pkg::ROW_W-1:0]    m_cursor_row,
    input logic [txtcon_pkg::COL_W-1:0]    m_cursor_column,
    input logic [txtcon_pkg::POS_W-1:0]    m_cursor_position,
    input logic                            m_scrolled
);

    // Geometry fits the port fields, so positions can be checked exactly
    localparam bit FITS = (COLUMNS <= 128) && (ROWS <= 32) && (ROWS * COLUMNS <= 2048);

    // Hold a stalled result transaction
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_value) && $stable(m_cursor_row)
            && $stable(m_cursor_column) && $stable(m_cursor_position) && $stable(m_scrolled))
        else $error("result transaction changed while stalled");

    // Reset starts the clearing pass: no request taken, no result shown
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("handshake active straight after reset");

    // Linear position agrees with row and column
    a_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && FITS |->
            m_cursor_position == txtcon_pkg::POS_W'(int'(m_cursor_row) * COLUMNS
                                                    + int'(m_cursor_column)))
        else $error("cursor position does not match row and column");

    // A scroll always leaves the cursor at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_scrolled |->
            m_cursor_row == txtcon_pkg::ROW_W'(ROWS - 1) && m_cursor_column == '0)
        else $error("scrolled result with cursor off the bottom row start");

endmodule

bind text_console_char_engine txtcon_port_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_txtcon_port_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_cell_value      (m_cell_value),
    .m_cursor_row      (m_cursor_row),
    .m_cursor_column   (m_cursor_column),
    .m_cursor_position (m_cursor_position),
    .m_scrolled        (m_scrolled)
);

/* test/text_console_char_engine_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for text_console_char_engine: a screen and cursor tracker
// predicts each result, plain tasks drive requests and text colour writes.
// Depends on txtcon_pkg and the engine RTL only.

module text_console_char_engine_tb;
    import txtcon_pkg::*;

    localparam int COLUMNS      = DEF_COLUMNS;
    localparam int ROWS         = DEF_ROWS;
    localparam int SCREEN_CELLS = COLUMNS * ROWS;
    localparam int PHASE_ITEMS  = 200;
    localparam int REPORT_LIMIT = 10;

    // One request transaction, as it stands on the s_ ports
    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } console_req_t;

    // One result transaction, as it stands on the m_ ports
    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
        logic [POS_W-1:0]  cursor_position;
        logic              scrolled;
    } console_res_t;

    // Shadow copy of the screen, the cursor and the text colour. Every accepted
    // request is applied here at once and the result it must produce is queued.
    class screen_tracker;
        logic [CELL_W-1:0] cells [SCREEN_CELLS];
        int unsigned       crow;
        int unsigned       ccol;
        logic [ATTR_W-1:0] colour;
        console_res_t      pending [$];
        int                mismatch_count;
        int                results_seen;
        int                scroll_count;
        int                op_seen [4];

        function new();
            colour = RESET_COLOR;
            blank_screen();
            crow = 0;
            ccol = 0;
        endfunction

        function void blank_screen();
            foreach (cells[i]) cells[i] = {colour, BLANK_CHAR};
        endfunction

        function void take_request(console_req_t rq);
            console_res_t want;
            int unsigned  r;
            int unsigned  c;
            want = '0;
            op_seen[rq.op]++;
            // Targets beyond the screen land on the last row or column
            r = (rq.row > ROWS - 1) ? ROWS - 1 : rq.row;
            c = (rq.col > COLUMNS - 1) ? COLUMNS - 1 : rq.col;
            case (rq.op)
                OP_PUT: begin
                    if (rq.ch == CH_NL) begin
                        ccol = 0;
                        crow++;
                    end else if (rq.ch == CH_CR) begin
                        ccol = 0;
                    end else if (rq.ch == CH_TAB) begin
                        ccol = (ccol + 8) & ~32'd7;
                    end else if (rq.ch == CH_BS) begin
                        if (ccol > 0) begin
                            ccol--;
                            cells[crow * COLUMNS + ccol] = {colour, BLANK_CHAR};
                        end
                    end else begin
                        cells[crow * COLUMNS + ccol] = {colour, rq.ch};
                        ccol++;
                    end
                    if (ccol >= COLUMNS) begin
                        ccol = 0;
                        crow++;
                    end
                    if (crow >= ROWS) begin
                        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                            cells[i] = cells[i + COLUMNS];
                        for (int i = (ROWS - 1) * COLUMNS; i < SCREEN_CELLS; i++)
                            cells[i] = {colour, BLANK_CHAR};
                        crow = ROWS - 1;
                        want.scrolled = 1'b1;
                        scroll_count++;
                    end
                end
                OP_READ: begin
                    want.cell_value = cells[r * COLUMNS + c];
                end
                OP_CLEAR: begin
                    blank_screen();
                    crow = 0;
                    ccol = 0;
                end
                default: begin
                    crow = r;
                    ccol = c;
                end
            endcase
            want.cursor_row      = ROW_W'(crow);
            want.cursor_column   = COL_W'(ccol);
            want.cursor_position = POS_W'(crow * COLUMNS + ccol);
            pending.push_back(want);
        endfunction

        function void match_result(console_res_t got);
            console_res_t want;
            if (pending.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result with nothing outstanding: cell=%h row=%0d col=%0d",
                             $realtime, got.cell_value, got.cursor_row, got.cursor_column);
                return;
            end
            want = pending.pop_front();
            results_seen++;
            if (got.cell_value !== want.cell_value || got.cursor_row !== want.cursor_row ||
                got.cursor_column !== want.cursor_column ||
                got.cursor_position !== want.cursor_position ||
                got.scrolled !== want.scrolled) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("%0t: result %0d expected cell=%h row=%0d col=%0d pos=%0d scr=%b",
                             $realtime, results_seen, want.cell_value, want.cursor_row,
                             want.cursor_column, want.cursor_position, want.scrolled);
                    $display("%0t: result %0d actual   cell=%h row=%0d col=%0d pos=%0d scr=%b",
                             $realtime, results_seen, got.cell_value, got.cursor_row,
                             got.cursor_column, got.cursor_position, got.scrolled);
                end
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [ATTR_W-1:0] cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    console_req_t      req_now = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [CELL_W-1:0] m_cell_value;
    logic [ROW_W-1:0]  m_cursor_row;
    logic [COL_W-1:0]  m_cursor_column;
    logic [POS_W-1:0]  m_cursor_position;
    logic              m_scrolled;
    console_res_t      res_now;

    screen_tracker     shadow;
    bit                calm = 1'b0;      // no idling on either side while set
    int                sent_items = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    text_console_char_engine dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (req_now.op),
        .s_char_code       (req_now.ch),
        .s_target_row      (req_now.row),
        .s_target_column   (req_now.col),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cell_value      (m_cell_value),
        .m_cursor_row      (m_cursor_row),
        .m_cursor_column   (m_cursor_column),
        .m_cursor_position (m_cursor_position),
        .m_scrolled        (m_scrolled)
    );

    assign res_now = '{m_cell_value, m_cursor_row, m_cursor_column, m_cursor_position,
                       m_scrolled};

    // Sample both channels at the rising edge; predict on every accepted request
    // and check every accepted result against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            shadow.take_request(req_now);
        if (aresetn && m_valid && m_ready)
            shadow.match_result(res_now);
    end

    // Receiver back-pressure: drop ready about 15 percent of the time
    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 15);
    end

    function automatic console_req_t make_req(op_t op, int unsigned ch, int unsigned row,
                                              int unsigned col);
        return '{op, CHAR_W'(ch), ROW_W'(row), COL_W'(col)};
    endfunction

    // Mostly printable text, with control codes and raw bytes mixed in
    function automatic int unsigned text_char();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 6)  return CH_NL;
        if (pick < 9)  return CH_CR;
        if (pick < 13) return CH_TAB;
        if (pick < 18) return CH_BS;
        if (pick < 28) return $urandom_range(0, 255);
        return $urandom_range(8'h20, 8'h7E);
    endfunction

    // Present one request and hold it until the engine takes it. Valid stays
    // high into the next request unless an idle gap is drawn.
    task automatic send_request(console_req_t rq);
        int gap;
        if (!calm && $urandom_range(99) < 15) begin
            gap = $urandom_range(1, 4);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        req_now <= rq;
        do @(posedge aclk); while (!s_ready);
        sent_items++;
    endtask

    // Drop valid, wait for every outstanding result, then let the engine settle
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (shadow.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_text_colour(logic [ATTR_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        shadow.colour = value;
    endtask

    // One burst of related requests, chosen at random
    task automatic random_burst();
        int   sel;
        op_t  op;
        sel = $urandom_range(99);
        if (sel < 45) begin
            // A run of text, sometimes from a fresh cursor position
            if ($urandom_range(1))
                send_request(make_req(OP_SETCUR, $urandom, $urandom_range(0, 31),
                                      $urandom_range(0, 127)));
            repeat ($urandom_range(3, 24))
                send_request(make_req(OP_PUT, text_char(), $urandom, $urandom));
        end else if (sel < 65) begin
            // Reads: anywhere, or along the cursor row to see what was written
            repeat ($urandom_range(1, 5)) begin
                if ($urandom_range(1))
                    send_request(make_req(OP_READ, $urandom, $urandom_range(0, 31),
                                          $urandom_range(0, 127)));
                else
                    send_request(make_req(OP_READ, $urandom, shadow.crow,
                                          $urandom_range(0, COLUMNS - 1)));
            end
        end else if (sel < 80) begin
            // Near the bottom right corner: wraps, tab overruns and scrolls
            send_request(make_req(OP_SETCUR, $urandom, $urandom_range(22, 31),
                                  $urandom_range(70, 127)));
            repeat ($urandom_range(1, 6))
                send_request(make_req(OP_PUT, text_char(), $urandom, $urandom));
        end else if (sel < 97) begin
            // Noise: any operation, any field; keep full-screen clears rare
            repeat ($urandom_range(1, 4)) begin
                op = op_t'($urandom_range(0, 3));
                if (op == OP_CLEAR && $urandom_range(9) != 0)
                    op = OP_READ;
                send_request(make_req(op, $urandom, $urandom, $urandom));
            end
        end else begin
            send_request(make_req(OP_CLEAR, $urandom, $urandom, $urandom));
        end
    endtask

    initial begin
        logic [ATTR_W-1:0] phase_colour [5];
        int                target;
        int                failures;
        shadow = new();
        phase_colour = '{8'h00, 8'hFF, 8'h1E, 8'($urandom), 8'($urandom)};

        // Hold reset low, then release it; the engine then runs its clearing pass
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes of every field and each special case, reset colour
        send_request(make_req(OP_READ, 0, 0, 0));
        send_request(make_req(OP_PUT, 8'h41, 0, 0));
        send_request(make_req(OP_PUT, 8'h00, 31, 127));
        send_request(make_req(OP_PUT, 8'hFF, 0, 0));
        send_request(make_req(OP_PUT, 8'h80, 0, 0));
        send_request(make_req(OP_PUT, CH_BS, 0, 0));
        send_request(make_req(OP_READ, 0, 0, 3));
        send_request(make_req(OP_READ, 0, 0, 2));
        send_request(make_req(OP_PUT, CH_TAB, 0, 0));
        send_request(make_req(OP_PUT, CH_CR, 0, 0));
        send_request(make_req(OP_PUT, CH_BS, 0, 0));             // backspace at column 0
        send_request(make_req(OP_SETCUR, 0, 31, 127));           // clamped to the corner
        send_request(make_req(OP_PUT, 8'h5A, 0, 0));             // wrap off the last row
        send_request(make_req(OP_READ, 0, 31, 127));
        send_request(make_req(OP_READ, 0, 23, 79));
        send_request(make_req(OP_SETCUR, 0, 24, 75));
        send_request(make_req(OP_PUT, CH_TAB, 0, 0));            // tab past the last column
        send_request(make_req(OP_SETCUR, 0, 24, 10));
        send_request(make_req(OP_PUT, CH_NL, 0, 0));             // newline on the last row
        send_request(make_req(OP_SETCUR, 0, 0, 79));
        send_request(make_req(OP_PUT, 8'h78, 0, 0));             // wrap without scrolling
        send_request(make_req(OP_READ, 0, 0, 79));
        send_request(make_req(OP_CLEAR, 0, 0, 0));
        send_request(make_req(OP_READ, 0, 22, 79));
        settle();

        // Random phases, each under its own text colour; the middle one never idles
        foreach (phase_colour[p]) begin
            set_text_colour(phase_colour[p]);
            calm = (p == 2);
            target = sent_items + PHASE_ITEMS;
            while (sent_items < target) random_burst();
            settle();
        end
        calm = 1'b0;

        failures = shadow.mismatch_count + shadow.pending.size();
        $display("run covered %0d requests: %0d put, %0d read, %0d clear, %0d set cursor",
                 sent_items, shadow.op_seen[OP_PUT], shadow.op_seen[OP_READ],
                 shadow.op_seen[OP_CLEAR], shadow.op_seen[OP_SETCUR]);
        $display("%0d results checked, %0d scrolls, %0d text colours, %0d failures",
                 shadow.results_seen, shadow.scroll_count, $size(phase_colour) + 1, failures);
        if (failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Guard against a hang: far beyond a run in which every request sweeps the screen
    initial begin
        #100_000_000;
        $display("timeout: engine stopped making progress");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
